// ===== sv/hie3_pkg.sv =====
// Shared types and constants for the 3-D Hilbert index encoder.
// No dependencies; used by every module of the encoder.
package hie3_pkg;

   localparam int MAX_LEVEL = 10;
   localparam int AXES      = 3;
   localparam int COORD_W   = 10;
   localparam int LEVEL_W   = 4;
   localparam int INDEX_W   = AXES * MAX_LEVEL;
   localparam int NCELL     = MAX_LEVEL - 1;

   typedef struct packed {
      logic [COORD_W-1:0] w0;
      logic [COORD_W-1:0] w1;
      logic [COORD_W-1:0] w2;
      logic [LEVEL_W-1:0] lv;
   } lane_type;

endpackage

// ===== sv/hie3_undo_cell.sv =====
// One bit plane of the inverse-undo pass, with its stage register.
// Depends on hie3_pkg.
module hie3_undo_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [hie3_pkg::LEVEL_W-1:0]  plane,
   input  logic                          in_valid,
   input  hie3_pkg::lane_type            in_lane,
   output logic                          out_valid,
   output hie3_pkg::lane_type            out_lane
);

   logic                valid_ff;
   hie3_pkg::lane_type  lane_ff;
   hie3_pkg::lane_type  lane_in;

   always_comb begin
      logic [hie3_pkg::COORD_W-1:0] pmask;
      logic [hie3_pkg::COORD_W-1:0] t;
      logic [hie3_pkg::COORD_W-1:0] w0;
      logic [hie3_pkg::COORD_W-1:0] w1;
      logic [hie3_pkg::COORD_W-1:0] w2;
      pmask = (hie3_pkg::COORD_W'(1) << plane) - hie3_pkg::COORD_W'(1);
      t  = '0;
      w0 = in_lane.w0;
      w1 = in_lane.w1;
      w2 = in_lane.w2;
      if (plane < in_lane.lv) begin
         if (w0[plane]) begin
            w0 = w0 ^ pmask;
         end
         if (w1[plane]) begin
            w0 = w0 ^ pmask;
         end else begin
            t  = (w0 ^ w1) & pmask;
            w0 = w0 ^ t;
            w1 = w1 ^ t;
         end
         if (w2[plane]) begin
            w0 = w0 ^ pmask;
         end else begin
            t  = (w0 ^ w2) & pmask;
            w0 = w0 ^ t;
            w2 = w2 ^ t;
         end
      end
      lane_in.w0 = w0;
      lane_in.w1 = w1;
      lane_in.w2 = w2;
      lane_in.lv = in_lane.lv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== sv/hie3_gray_pack.sv =====
// Gray encode and bit interleave, with the result word register.
// Depends on hie3_pkg.
module hie3_gray_pack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  hie3_pkg::lane_type            in_lane,
   output logic                          out_valid,
   output logic [hie3_pkg::INDEX_W-1:0]  out_index
);

   logic                          valid_ff;
   logic [hie3_pkg::INDEX_W-1:0]  index_ff;
   logic [hie3_pkg::INDEX_W-1:0]  index_in;

   always_comb begin
      logic [hie3_pkg::COORD_W-1:0] g0;
      logic [hie3_pkg::COORD_W-1:0] g1;
      logic [hie3_pkg::COORD_W-1:0] g2;
      logic [hie3_pkg::COORD_W-1:0] t;
      g0 = in_lane.w0;
      g1 = in_lane.w1 ^ g0;
      g2 = in_lane.w2 ^ g1;
      // t bit i: parity of g2 bits above i
      for (int i = 0; i < hie3_pkg::COORD_W; i++) begin
         t[i] = ^(g2 >> (i + 1));
      end
      g0 = g0 ^ t;
      g1 = g1 ^ t;
      g2 = g2 ^ t;
      for (int b = 0; b < hie3_pkg::MAX_LEVEL; b++) begin
         index_in[b*hie3_pkg::AXES + 0] = g2[b];
         index_in[b*hie3_pkg::AXES + 1] = g1[b];
         index_in[b*hie3_pkg::AXES + 2] = g0[b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         index_ff <= index_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_index = index_ff;

endmodule

// ===== sv/hilbert_index_encode_3d.sv =====
// 3-D Hilbert index encoder: input register, one undo cell per bit plane, Gray/pack stage.
// Pipeline: MAX_LEVEL + 1 registers from accepted word to result word.
// Throughput: one word per cycle; the whole chain holds while the result word is stalled.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// Depends on hie3_pkg, hie3_undo_cell, hie3_gray_pack.
module hilbert_index_encode_3d (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hie3_pkg::COORD_W-1:0]  req_x_coord,
   input  logic [hie3_pkg::COORD_W-1:0]  req_y_coord,
   input  logic [hie3_pkg::COORD_W-1:0]  req_z_coord,
   input  logic [hie3_pkg::LEVEL_W-1:0]  req_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hie3_pkg::INDEX_W-1:0]  rsp_hilbert_index
);

   logic                          adv;
   logic                          valid_ff [hie3_pkg::NCELL+1];
   hie3_pkg::lane_type            stage    [hie3_pkg::NCELL+1];
   hie3_pkg::lane_type            lane_ff;
   hie3_pkg::lane_type            lane_in;
   logic                          in_valid_ff;
   logic [hie3_pkg::LEVEL_W-1:0]  lv;
   logic [hie3_pkg::COORD_W-1:0]  cmask;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      lv = (req_level > hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL))
           ? hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL) : req_level;
      cmask = (hie3_pkg::COORD_W'(1) << lv) - hie3_pkg::COORD_W'(1);
      lane_in.w0 = req_x_coord & cmask;
      lane_in.w1 = req_y_coord & cmask;
      lane_in.w2 = req_z_coord & cmask;
      lane_in.lv = lv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign valid_ff[0] = in_valid_ff;
   assign stage[0]    = lane_ff;

   for (genvar k = 0; k < hie3_pkg::NCELL; k++) begin : g_cell
      hie3_undo_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .plane     (hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL - 1 - k)),
         .in_valid  (valid_ff[k]),
         .in_lane   (stage[k]),
         .out_valid (valid_ff[k+1]),
         .out_lane  (stage[k+1])
      );
   end

   hie3_gray_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (valid_ff[hie3_pkg::NCELL]),
      .in_lane   (stage[hie3_pkg::NCELL]),
      .out_valid (rsp_valid),
      .out_index (rsp_hilbert_index)
   );

   a_level_sat: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> stage[0].lv <= hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL))
      else $error("level above maximum in chain");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && valid_ff[hie3_pkg::NCELL] && stage[hie3_pkg::NCELL].lv == '0)
      |=> (rsp_valid && rsp_hilbert_index == '0))
      else $error("level zero gave nonzero index");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(valid_ff[hie3_pkg::NCELL]) && $stable(stage[hie3_pkg::NCELL])))
      else $error("chain moved while result stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (adv && valid_ff[hie3_pkg::NCELL]) |=> rsp_valid)
      else $error("word lost at last stage");

endmodule

// ===== tb/sv/tb_hilbert_index_encode_3d.sv =====
// Self-checking testbench for hilbert_index_encode_3d: directed and random cell words,
// a scoreboard class that predicts each Hilbert index, random idling on both channels.
// Depends on hie3_pkg and the hilbert_index_encode_3d RTL.
`timescale 1ns / 1ps

module tb_hilbert_index_encode_3d;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_WORDS = 2000;

   class index_scoreboard;
      logic [hie3_pkg::INDEX_W-1:0] pending_index[$];
      int errors = 0;

      function logic [hie3_pkg::INDEX_W-1:0] hilbert_of(
         input logic [hie3_pkg::COORD_W-1:0] xc, input logic [hie3_pkg::COORD_W-1:0] yc,
         input logic [hie3_pkg::COORD_W-1:0] zc, input logic [hie3_pkg::LEVEL_W-1:0] lvl);
         logic [hie3_pkg::COORD_W-1:0] w [hie3_pkg::AXES];
         logic [hie3_pkg::COORD_W-1:0] msk;
         logic [hie3_pkg::COORD_W-1:0] p;
         logic [hie3_pkg::COORD_W-1:0] t;
         logic [hie3_pkg::INDEX_W-1:0] idx;
         int lv;
         lv = (lvl > hie3_pkg::MAX_LEVEL) ? hie3_pkg::MAX_LEVEL : int'(lvl);
         if (lv == 0) return '0;
         msk = hie3_pkg::COORD_W'((1 << lv) - 1);
         w[0] = xc & msk;
         w[1] = yc & msk;
         w[2] = zc & msk;
         // undo pass, top plane down to bit 1
         for (int q = lv - 1; q >= 1; q--) begin
            p = hie3_pkg::COORD_W'((1 << q) - 1);
            for (int a = 0; a < hie3_pkg::AXES; a++) begin
               if (w[a][q]) begin
                  w[0] = w[0] ^ p;
               end else begin
                  t = (w[0] ^ w[a]) & p;
                  w[0] = w[0] ^ t;
                  w[a] = w[a] ^ t;
               end
            end
         end
         // Gray encode
         for (int a = 1; a < hie3_pkg::AXES; a++) w[a] = w[a] ^ w[a-1];
         t = '0;
         for (int q = lv - 1; q >= 1; q--) begin
            if (w[hie3_pkg::AXES-1][q]) t = t ^ hie3_pkg::COORD_W'((1 << q) - 1);
         end
         for (int a = 0; a < hie3_pkg::AXES; a++) w[a] = w[a] ^ t;
         // x is the top bit of each triple
         idx = '0;
         for (int b = 0; b < lv; b++) begin
            for (int a = 0; a < hie3_pkg::AXES; a++) begin
               idx[b*hie3_pkg::AXES + a] = w[hie3_pkg::AXES-1-a][b];
            end
         end
         return idx;
      endfunction

      function void note_cell(
         input logic [hie3_pkg::COORD_W-1:0] xc, input logic [hie3_pkg::COORD_W-1:0] yc,
         input logic [hie3_pkg::COORD_W-1:0] zc, input logic [hie3_pkg::LEVEL_W-1:0] lvl);
         pending_index = {pending_index, hilbert_of(xc, yc, zc, lvl)};
      endfunction

      function void check_index(input logic [hie3_pkg::INDEX_W-1:0] actual);
         logic [hie3_pkg::INDEX_W-1:0] expected;
         if (pending_index.size() == 0) begin
            $error("unexpected result word: hilbert_index actual %0d", actual);
            errors++;
            return;
         end
         expected = pending_index.pop_front();
         if (actual !== expected) begin
            $error("hilbert_index mismatch: expected %0d actual %0d", expected, actual);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [hie3_pkg::COORD_W-1:0]   req_x_coord = '0;
   logic [hie3_pkg::COORD_W-1:0]   req_y_coord = '0;
   logic [hie3_pkg::COORD_W-1:0]   req_z_coord = '0;
   logic [hie3_pkg::LEVEL_W-1:0]   req_level = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [hie3_pkg::INDEX_W-1:0]   rsp_hilbert_index;

   index_scoreboard sb = new;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int quiet_cycles = 0;

   hilbert_index_encode_3d dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .req_z_coord       (req_z_coord),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hilbert_index (rsp_hilbert_index)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_index(rsp_hilbert_index);
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic send_cell(
      input logic [hie3_pkg::COORD_W-1:0] xc, input logic [hie3_pkg::COORD_W-1:0] yc,
      input logic [hie3_pkg::COORD_W-1:0] zc, input logic [hie3_pkg::LEVEL_W-1:0] lvl);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      req_z_coord <= zc;
      req_level   <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_cell(xc, yc, zc, lvl);
   endtask

   task automatic send_random_cells(input int count);
      logic [hie3_pkg::LEVEL_W-1:0] lvl;
      for (int i = 0; i < count; i++) begin
         // mostly legal levels, some above the maximum to cover saturation
         lvl = ($urandom_range(9) == 0)
               ? hie3_pkg::LEVEL_W'($urandom_range(15))
               : hie3_pkg::LEVEL_W'($urandom_range(hie3_pkg::MAX_LEVEL, 1));
         send_cell(hie3_pkg::COORD_W'($urandom), hie3_pkg::COORD_W'($urandom),
                   hie3_pkg::COORD_W'($urandom), lvl);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 16;
      rsp_idle_pct = 58;

      send_cell('1, '1, '1, 4'd0);
      send_cell('0, '0, '0, 4'd0);
      send_cell(10'd0, 10'd0, 10'd0, 4'd1);
      send_cell(10'd1, 10'd0, 10'd0, 4'd1);
      send_cell(10'd0, 10'd1, 10'd0, 4'd1);
      send_cell(10'd0, 10'd0, 10'd1, 4'd1);
      send_cell(10'd1, 10'd1, 10'd1, 4'd1);
      send_cell(10'd3, 10'd2, 10'd1, 4'd2);
      send_cell('1, '1, '1, 4'd3);
      send_cell(10'h2AA, 10'h155, 10'h3F0, 4'd5);
      send_cell(10'h1FF, 10'h100, 10'h0FF, 4'd9);
      send_cell('0, '0, '0, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell('1, '1, '1, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell('1, '0, '0, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell('0, '1, '0, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell('0, '0, '1, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell(10'h2AA, 10'h155, 10'h2AA, hie3_pkg::LEVEL_W'(hie3_pkg::MAX_LEVEL));
      send_cell(10'h155, 10'h2AA, 10'h155, 4'd11);
      send_cell('1, '1, '1, 4'd15);
      send_cell(10'h3A5, 10'h05A, 10'h2C3, 4'd12);

      send_random_cells(RANDOM_WORDS / 3);
      req_idle_pct = 58;
      rsp_idle_pct = 16;
      send_random_cells(RANDOM_WORDS / 3);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_cells(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
      req_valid <= 1'b0;

      while (sb.pending_index.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_index.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
